// ===== src/nnst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnst_pkg
// Shared types, codes and default sizes for the nearest node search table.
// ----------------------------------------------------------------------------
package nnst_pkg;

    typedef logic [1:0] opcode_t;
    typedef logic [1:0] status_t;

    localparam opcode_t OP_CLEAR  = 2'd0;
    localparam opcode_t OP_INSERT = 2'd1;
    localparam opcode_t OP_QUERY  = 2'd2;
    localparam opcode_t OP_NOP    = 2'd3;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_FULL  = 2'd1;
    localparam status_t STAT_EMPTY = 2'd2;

    // Fixed widths of the result fields
    localparam int INDEX_OUT_W = 8;
    localparam int DIST_OUT_W  = 33;
    localparam int COUNT_OUT_W = 9;

    // Defaults
    localparam int MAX_NODES_DEF  = 256;
    localparam int COORD_BITS_DEF = 16;
    localparam int IDX_W_DEF      = 8;
    localparam int DIST_W_DEF     = 33;

endpackage

// ===== src/nnst_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnst_dist
// Three-stage squared Euclidean distance unit: |dx|,|dy| -> squares -> sum.
// The index rides along with the data; sum saturates to all ones on overflow.
// ----------------------------------------------------------------------------
module nnst_dist #(
    parameter int COORD_BITS = nnst_pkg::COORD_BITS_DEF,
    parameter int IDX_W      = nnst_pkg::IDX_W_DEF,
    parameter int DIST_W     = nnst_pkg::DIST_W_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid,
    input  logic [IDX_W-1:0]             idx,
    input  logic signed [COORD_BITS-1:0] node_x,
    input  logic signed [COORD_BITS-1:0] node_y,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    output logic                         dist_valid,
    output logic [DIST_W-1:0]            sq_dist,
    output logic [IDX_W-1:0]             dist_idx
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 1;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS:0]        dx_neg;
    logic [COORD_BITS:0]        dy_neg;
    logic [COORD_BITS-1:0]      mag_x_next;
    logic [COORD_BITS-1:0]      mag_y_next;
    logic [SQ_W-1:0]            sq_x_next;
    logic [SQ_W-1:0]            sq_y_next;
    logic [SUM_W-1:0]           sum;
    logic                       sum_ovf;
    logic [DIST_W-1:0]          dist_next;

    logic                  a_valid_reg;
    logic                  b_valid_reg;
    logic                  c_valid_reg;
    logic [IDX_W-1:0]      a_idx_reg;
    logic [IDX_W-1:0]      b_idx_reg;
    logic [IDX_W-1:0]      c_idx_reg;
    logic [COORD_BITS-1:0] mag_x_reg;
    logic [COORD_BITS-1:0] mag_y_reg;
    logic [SQ_W-1:0]       sq_x_reg;
    logic [SQ_W-1:0]       sq_y_reg;
    logic [DIST_W-1:0]     dist_reg;

    // |a - b| of two signed values fits in COORD_BITS unsigned bits
    always_comb
    begin
        dx         = {node_x[COORD_BITS-1], node_x} - {point_x[COORD_BITS-1], point_x};
        dy         = {node_y[COORD_BITS-1], node_y} - {point_y[COORD_BITS-1], point_y};
        dx_neg     = -dx;
        dy_neg     = -dy;
        mag_x_next = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        mag_y_next = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    end

    assign sq_x_next = SQ_W'(mag_x_reg) * SQ_W'(mag_x_reg);
    assign sq_y_next = SQ_W'(mag_y_reg) * SQ_W'(mag_y_reg);

    always_comb
    begin
        sum       = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
        sum_ovf   = (SUM_W > DIST_W) && sum[SUM_W-1];
        dist_next = sum_ovf ? {DIST_W{1'b1}} : DIST_W'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg <= idx;
        mag_x_reg <= mag_x_next;
        mag_y_reg <= mag_y_next;
        b_idx_reg <= a_idx_reg;
        sq_x_reg  <= sq_x_next;
        sq_y_reg  <= sq_y_next;
        c_idx_reg <= b_idx_reg;
        dist_reg  <= dist_next;
    end

    assign dist_valid = c_valid_reg;
    assign sq_dist    = dist_reg;
    assign dist_idx   = c_idx_reg;

endmodule

// ===== src/nearest_node_search_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_node_search_table
// Node position table with clear, insert and linear nearest-node query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, pos_x, pos_y (signed
//   Q8.8). Output channel (out_valid/out_ready) returns one transaction per
//   input: status, node_index, square_dist and node_count.
//   Clear, insert and the unused opcode pass from idle through the done state
//   to the output register. A query on N stored nodes streams the node memory
//   one entry per cycle through a 3-stage distance pipe from the single
//   registered read port of the node memory, then passes through the done
//   state likewise. A query on an empty table finishes like an insert.
//   The block returns to idle in the same cycle that out_valid rises, so the
//   next transaction can be taken from then on, while the result is offered.
//   One transaction is in work at a time. in_ready is high while the block is
//   idle, also while the previous result still sits in the output register.
//   A finished result waits inside until the output register is free, so a
//   stalled receiver holds the block after at most one further transaction.
//   Reset empties the table (count zero) and drops any pending result; the
//   node memory itself is not cleared, entries are written before use.
//   Ties in distance go to the lowest index.
// ----------------------------------------------------------------------------
module nearest_node_search_table #(
    parameter int MAX_NODES  = nnst_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = nnst_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  nnst_pkg::opcode_t                   opcode,
    input  logic signed [COORD_BITS-1:0]        pos_x,
    input  logic signed [COORD_BITS-1:0]        pos_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output nnst_pkg::status_t                   status,
    output logic [nnst_pkg::INDEX_OUT_W-1:0]    node_index,
    output logic [nnst_pkg::DIST_OUT_W-1:0]     square_dist,
    output logic [nnst_pkg::COUNT_OUT_W-1:0]    node_count
);

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int DIST_W = (2 * COORD_BITS + 1 > 64) ? 64 : 2 * COORD_BITS + 1;
    localparam int ENT_W  = 2 * COORD_BITS;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] issue_reg, issue_next;

    logic signed [COORD_BITS-1:0] qx_reg;
    logic signed [COORD_BITS-1:0] qy_reg;

    nnst_pkg::status_t                res_status_reg, res_status_next;
    logic [nnst_pkg::INDEX_OUT_W-1:0] res_index_reg, res_index_next;
    logic [nnst_pkg::DIST_OUT_W-1:0]  res_dist_reg, res_dist_next;

    logic                             out_valid_reg, out_valid_next;
    nnst_pkg::status_t                out_status_reg;
    logic [nnst_pkg::INDEX_OUT_W-1:0] out_index_reg;
    logic [nnst_pkg::DIST_OUT_W-1:0]  out_dist_reg;
    logic [nnst_pkg::COUNT_OUT_W-1:0] out_count_reg;

    logic [ENT_W-1:0] node_mem [MAX_NODES];
    logic [ENT_W-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0]  best_idx_reg;

    logic              in_accept;
    logic              full;
    logic              mem_we;
    logic              issuing;
    logic              out_load;
    logic              d_valid;
    logic [DIST_W-1:0] d_dist;
    logic [IDX_W-1:0]  d_idx;
    logic              d_first;
    logic              d_last;
    logic              take;
    logic [DIST_W-1:0] win_dist;
    logic [IDX_W-1:0]  win_idx;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign full      = (cnt_reg == MAX_CNT);
    assign mem_we    = in_accept && (opcode == nnst_pkg::OP_INSERT) && !full;
    assign issuing   = (state_reg == ST_SCAN) && (issue_reg < cnt_reg);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Node memory: one write port (insert), one registered read port (scan)
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[cnt_reg[IDX_W-1:0]] <= {pos_y, pos_x};
        end
        rd_data_reg <= node_mem[issue_reg[IDX_W-1:0]];
        rd_idx_reg  <= issue_reg[IDX_W-1:0];
    end

    nnst_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W),
        .DIST_W     (DIST_W)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (rd_valid_reg),
        .idx        (rd_idx_reg),
        .node_x     (rd_data_reg[COORD_BITS-1:0]),
        .node_y     (rd_data_reg[ENT_W-1:COORD_BITS]),
        .point_x    (qx_reg),
        .point_y    (qy_reg),
        .dist_valid (d_valid),
        .sq_dist    (d_dist),
        .dist_idx   (d_idx)
    );

    // Strict compare keeps the lowest index on ties
    always_comb
    begin
        d_first  = (d_idx == '0);
        d_last   = (CNT_W'(d_idx) == cnt_reg - CNT_W'(1));
        take     = d_first || (d_dist < best_dist_reg);
        win_dist = take ? d_dist : best_dist_reg;
        win_idx  = take ? d_idx : best_idx_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        issue_next      = issue_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_dist_next   = res_dist_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                issue_next = '0;
                if (in_accept)
                begin
                    res_status_next = nnst_pkg::STAT_OK;
                    res_index_next  = '0;
                    res_dist_next   = '0;
                    state_next      = ST_DONE;
                    unique case (opcode)
                        nnst_pkg::OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        nnst_pkg::OP_INSERT:
                        begin
                            if (full)
                            begin
                                res_status_next = nnst_pkg::STAT_FULL;
                            end
                            else
                            begin
                                res_index_next = nnst_pkg::INDEX_OUT_W'(cnt_reg);
                                cnt_next       = cnt_reg + CNT_W'(1);
                            end
                        end
                        nnst_pkg::OP_QUERY:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = nnst_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        nnst_pkg::OP_NOP:
                        begin
                            cnt_next = cnt_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issuing)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (d_valid && d_last)
                begin
                    res_status_next = nnst_pkg::STAT_OK;
                    res_index_next  = nnst_pkg::INDEX_OUT_W'(win_idx);
                    res_dist_next   = nnst_pkg::DIST_OUT_W'(win_dist);
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= issuing;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            qx_reg <= pos_x;
            qy_reg <= pos_y;
        end
        if (d_valid)
        begin
            best_dist_reg <= win_dist;
            best_idx_reg  <= win_idx;
        end
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_dist_reg   <= res_dist_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_dist_reg   <= res_dist_reg;
            out_count_reg  <= nnst_pkg::COUNT_OUT_W'(cnt_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign node_index  = out_index_reg;
    assign square_dist = out_dist_reg;
    assign node_count  = out_count_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("node count above table size");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && opcode == nnst_pkg::OP_INSERT && !full)
        |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("insert did not advance node count");

    a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid |-> state_reg == ST_SCAN)
        else $error("distance result outside of a scan");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished result not moved to output");

endmodule
